>>> rtl/scc_pkg.sv
// Package for the stack calculator: codes, sizes and controller/datapath link types.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_TOP  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_MUL  = 3'd5,
        OP_DIV  = 3'd6,
        OP_NOP  = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_RDATA = 2'd1,
        RES_ALU   = 2'd2,
        RES_QUOT  = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     rd_top;
        logic     rd_second;
        logic     lat_a;
        logic     lat_b;
        logic     cnt_inc;
        logic     cnt_dec1;
        logic     cnt_dec2;
        logic     wr_push;
        logic     wr_res;
        logic     set_res;
        status_t  res_status;
        res_sel_t res_sel;
        logic     div_start;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic lt2;
        logic a_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/scc_cmd_if.sv
// Channel interfaces for instruction items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface scc_cmd_if;
    import scc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface scc_rsp_if;
    import scc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] value;
    logic [DEPTH_W-1:0]       depth;

    modport source (output valid, output status, output value, output depth, input ready);
    modport sink   (input valid, input status, input value, input depth, output ready);
endinterface
`default_nettype wire

>>> rtl/scc_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module scc_div
    import scc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [WORD_W-1:0] dividend,
    input  wire logic signed [WORD_W-1:0] divisor,
    output logic                          done,
    output logic signed [WORD_W-1:0]      quotient
);

    localparam int ITER_W = $clog2(WORD_W);

    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dsr_reg;
    logic              neg_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [WORD_W-1:0] dvd_mag;
    logic [WORD_W-1:0] dsr_mag;
    logic [WORD_W:0]   rem_shift;
    logic              ge;
    logic [WORD_W:0]   rem_diff;

    assign dvd_mag   = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
    assign dsr_mag   = divisor[WORD_W-1]  ? (~divisor + WORD_W'(1))  : divisor;
    assign rem_shift = {rem_reg, dvd_reg[WORD_W-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(WORD_W - 1);
            end
            else if (busy_reg)
            begin
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg - ITER_W'(1);
                end
            end
        end
    end

    // Shift the dividend out at the top and the quotient bits in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dvd_mag;
            dsr_reg <= dsr_mag;
            rem_reg <= '0;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
            dvd_reg <= {dvd_reg[WORD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~dvd_reg + WORD_W'(1)) : dvd_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_done_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("divider done while still busy");

endmodule
`default_nettype wire

>>> rtl/scc_ctrl.sv
// Controller state machine: sequences decode, stack reads, execute, write-back and result.
`timescale 1ns / 1ps
`default_nettype none
module scc_ctrl
    import scc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOP,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl        = '0;
        ctl.res_status = ST_OK;
        ctl.res_sel    = RES_ZERO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (sts.op)
                    OP_PUSH:
                    begin
                        ctl.set_res = 1'b1;
                        if (sts.full)
                        begin
                            ctl.res_status = ST_OVER;
                        end
                        else
                        begin
                            ctl.wr_push = 1'b1;
                            ctl.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        ctl.set_res = 1'b1;
                        if (sts.empty)
                            ctl.res_status = ST_UNDER;
                        else
                            ctl.cnt_dec1 = 1'b1;
                    end
                    OP_TOP:
                    begin
                        if (sts.empty)
                        begin
                            ctl.set_res    = 1'b1;
                            ctl.res_status = ST_UNDER;
                        end
                        else
                        begin
                            ctl.rd_top = 1'b1;
                            state_next = S_TOP;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (sts.lt2)
                        begin
                            ctl.set_res    = 1'b1;
                            ctl.res_status = ST_UNDER;
                        end
                        else
                        begin
                            ctl.rd_top = 1'b1;
                            state_next = S_RD_A;
                        end
                    end
                    default:
                    begin
                        ctl.set_res = 1'b1;
                    end
                endcase
            end
            S_TOP:
            begin
                ctl.set_res = 1'b1;
                ctl.res_sel = RES_RDATA;
                state_next  = S_FINISH;
            end
            S_RD_A:
            begin
                ctl.lat_a     = 1'b1;
                ctl.rd_second = 1'b1;
                state_next    = S_RD_B;
            end
            S_RD_B:
            begin
                ctl.lat_b    = 1'b1;
                ctl.cnt_dec2 = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.op == OP_DIV)
                begin
                    if (sts.a_zero)
                    begin
                        ctl.set_res    = 1'b1;
                        ctl.res_status = ST_DIVZ;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        ctl.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    ctl.set_res = 1'b1;
                    ctl.res_sel = RES_ALU;
                    state_next  = S_WRITE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.set_res = 1'b1;
                    ctl.res_sel = RES_QUOT;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ctl.wr_res  = 1'b1;
                ctl.cnt_inc = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> rtl/scc_dpath.sv
// Datapath: stack memory, depth counter, operand and result registers, ALU and divider.
`timescale 1ns / 1ps
`default_nettype none
module scc_dpath
    import scc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [OP_W-1:0]          cmd_op,
    input  wire logic signed [WORD_W-1:0] cmd_push_value,
    input  wire ctrl_cmd_t                ctl,
    output dp_status_t                    sts,
    scc_rsp_if.source                     rsp
);

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    op_t                      op_reg;
    logic signed [WORD_W-1:0] push_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic signed [WORD_W-1:0] a_reg;
    logic signed [WORD_W-1:0] b_reg;
    status_t                  res_status_reg;
    logic signed [WORD_W-1:0] res_value_reg;
    logic signed [WORD_W-1:0] res_value_next;
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [WORD_W-1:0] out_value_reg;
    logic [DEPTH_W-1:0]       out_depth_reg;

    logic [PTR_W-1:0]         rd_addr;
    logic [PTR_W-1:0]         wr_addr;
    logic signed [WORD_W-1:0] alu;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_quot;

    scc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Top sits at count-1, second at count-2.
    assign rd_addr = ctl.rd_second ? PTR_W'(count_reg - CNT_W'(2))
                                   : PTR_W'(count_reg - CNT_W'(1));
    assign wr_addr = PTR_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.rd_top || ctl.rd_second)
            rdata_reg <= mem[rd_addr];
        if (ctl.wr_push)
            mem[wr_addr] <= push_reg;
        else if (ctl.wr_res)
            mem[wr_addr] <= res_value_reg;
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu = a_reg + b_reg;
            OP_SUB:  alu = b_reg - a_reg;
            OP_MUL:  alu = WORD_W'(a_reg * b_reg);
            default: alu = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.res_sel)
            RES_RDATA: res_value_next = rdata_reg;
            RES_ALU:   res_value_next = alu;
            RES_QUOT:  res_value_next = div_quot;
            default:   res_value_next = '0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.cnt_dec1)
            count_next = count_reg - CNT_W'(1);
        else if (ctl.cnt_dec2)
            count_next = count_reg - CNT_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= op_t'(cmd_op);
            push_reg <= cmd_push_value;
        end
        if (ctl.lat_a)
            a_reg <= rdata_reg;
        if (ctl.lat_b)
            b_reg <= rdata_reg;
        if (ctl.set_res)
        begin
            res_status_reg <= ctl.res_status;
            res_value_reg  <= res_value_next;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= (res_status_reg == ST_OK) ? res_value_reg : '0;
            out_depth_reg  <= DEPTH_W'(count_reg);
        end
    end

    assign sts.op       = op_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg >= CNT_W'(STACK_DEPTH));
    assign sts.lt2      = (count_reg < CNT_W'(2));
    assign sts.a_zero   = (a_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.depth  = out_depth_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance count");
    a_pop2_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_dec2 |-> count_reg >= CNT_W'(2))
        else $error("operand pop with fewer than two entries");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !out_valid_reg || rsp.ready)
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

>>> rtl/stack_calculator_core_unit.sv
// Top level of the 32-bit integer stack calculator.
//
//   channel  modport        payload                       role
//   cmd      scc_cmd_if.sink   op[2:0], push_value[31:0]     instruction items in
//   rsp      scc_rsp_if.source status[1:0], value[31:0],    one result item per
//                              depth[6:0]                    instruction
//
// Push, pop and no-op go from decode to result; top first reads the stack;
// add, subtract, multiply and divide read both operands, execute (divide in
// the one-bit-per-cycle divider) and write back; a zero divisor skips both.
// Input waits until the result is loaded. The stack memory has a single
// registered read port, so the operands are fetched in consecutive cycles.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending
// result; memory contents are not cleared and need not be.
// A stalled rsp holds the result register; the next instruction is still
// accepted and runs up to its result stage, then waits there for rsp.
`timescale 1ns / 1ps
`default_nettype none
module stack_calculator_core_unit
    import scc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    scc_cmd_if.sink   cmd,
    scc_rsp_if.source rsp
);

    ctrl_cmd_t  ctl;
    dp_status_t sts;
    logic       ctrl_ready;

    // Controller owns the handshake on the instruction side.
    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (ctrl_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    assign cmd.ready = ctrl_ready;

    // Datapath holds the stack, the operands and the result register.
    scc_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_op         (cmd.op),
        .cmd_push_value (cmd.push_value),
        .ctl            (ctl),
        .sts            (sts),
        .rsp            (rsp)
    );

endmodule
`default_nettype wire

>>> sim/stack_calculator_core_unit_checker.sv
// Result checker for the stack calculator: predicts each result item and compares it.
`timescale 1ns / 1ps
module stack_calculator_core_unit_checker
    import scc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    scc_cmd_if   cmd,
    scc_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
    } result_t;

    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    int                stack_level;
    result_t           pending_results [$];

    // Apply one instruction to the shadow stack and build its result item.
    task automatic execute_instruction(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] operand,
                                       output result_t res);
        logic [WORD_W-1:0]  top_word;
        logic [WORD_W-1:0]  second_word;
        logic signed [63:0] dividend;
        logic signed [63:0] divisor;
        logic signed [63:0] quotient;
        res.status = ST_OK;
        res.value  = '0;
        case (op_t'(op))
            OP_PUSH:
            begin
                if (stack_level >= STACK_DEPTH)
                begin
                    res.status = ST_OVER;
                end
                else
                begin
                    stack_words[stack_level] = operand;
                    stack_level++;
                end
            end
            OP_POP:
            begin
                if (stack_level == 0)
                    res.status = ST_UNDER;
                else
                    stack_level--;
            end
            OP_TOP:
            begin
                if (stack_level == 0)
                    res.status = ST_UNDER;
                else
                    res.value = stack_words[stack_level-1];
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (stack_level < 2)
                begin
                    res.status = ST_UNDER;
                end
                else
                begin
                    top_word    = stack_words[stack_level-1];
                    second_word = stack_words[stack_level-2];
                    stack_level -= 2;
                    if (op_t'(op) == OP_DIV && top_word == '0)
                    begin
                        // both operands are gone, nothing is pushed
                        res.status = ST_DIVZ;
                    end
                    else
                    begin
                        case (op_t'(op))
                            OP_ADD: res.value = second_word + top_word;
                            OP_SUB: res.value = second_word - top_word;
                            OP_MUL: res.value = second_word * top_word;
                            default:
                            begin
                                // widen so that minimum over minus one wraps cleanly
                                dividend  = $signed(second_word);
                                divisor   = $signed(top_word);
                                quotient  = dividend / divisor;
                                res.value = quotient[WORD_W-1:0];
                            end
                        endcase
                        stack_words[stack_level] = res.value;
                        stack_level++;
                    end
                end
            end
            default: ;
        endcase
        res.depth = DEPTH_W'(stack_level);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t predicted;
        result_t wanted;
        if (!rst_n)
        begin
            stack_level = 0;
            pending_results.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no instruction waiting: status %0d value %0d depth %0d",
                           rsp.status, rsp.value, rsp.depth);
                    fail_count++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (rsp.status !== wanted.status)
                    begin
                        $error("status: expected %0d, actual %0d", wanted.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.value !== wanted.value)
                    begin
                        $error("value: expected %0d, actual %0d",
                               $signed(wanted.value), rsp.value);
                        fail_count++;
                    end
                    if (rsp.depth !== wanted.depth)
                    begin
                        $error("depth: expected %0d, actual %0d", wanted.depth, rsp.depth);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                execute_instruction(cmd.op, cmd.push_value, predicted);
                pending_results.push_back(predicted);
            end
            pending = pending_results.size();
        end
    end

endmodule

>>> sim/stack_calculator_core_unit_tb.sv
// Testbench top for the stack calculator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module stack_calculator_core_unit_tb;
    import scc_pkg::*;

    // Slowest item is a divide, plus the idle gaps drawn on each side; the
    // limit sits several times above the slowest correct run.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1250;
    // Settle time after the last result item, so a stray extra item is caught.
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   items_sent;
    int   source_burst;
    int   sink_burst;

    scc_cmd_if cmd_ch ();
    scc_rsp_if rsp_ch ();

    stack_calculator_core_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    stack_calculator_core_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Draw the idle cycles before the next item. Now and then start a burst
    // of items with no idling at all, so back-to-back traffic is covered too.
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Pick a push operand, biased toward the word extremes and toward zero
    // so that divide by zero and wrapping arithmetic come up often.
    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // Drive one instruction item at the falling edge and hold it until the
    // block takes it. Valid stays high when the next item follows at once,
    // so it is never dropped and raised again within one step.
    task automatic send_instruction(input op_t op, input logic [WORD_W-1:0] operand);
        int gap;
        gap = draw_wait(source_burst);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.op         = op;
        // the payload is ignored for everything but push: toggle it anyway
        cmd_ch.push_value = (op == OP_PUSH) ? operand : $urandom();
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        @(negedge clk);
        items_sent++;
    endtask

    // Result side: stall a random number of cycles before each result item.
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(sink_burst);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        int   segment;
        int   roll;
        op_t  op;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_PUSH;
        cmd_ch.push_value = '0;
        rst_n             = 1'b0;
        cycle_count       = 0;
        items_sent        = 0;
        source_burst      = 0;
        sink_burst        = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: top, pop and add on an empty stack, arithmetic with a single
        // entry, minimum over minus one, divide by zero, the word extremes,
        // the operand order of subtract and divide, and the unused op code.
        send_instruction(OP_TOP,  '0);
        send_instruction(OP_POP,  '0);
        send_instruction(OP_ADD,  '0);
        send_instruction(OP_PUSH, 32'h7FFF_FFFF);
        send_instruction(OP_ADD,  '0);
        send_instruction(OP_PUSH, 32'h8000_0000);
        send_instruction(OP_PUSH, 32'hFFFF_FFFF);
        send_instruction(OP_DIV,  '0);
        send_instruction(OP_TOP,  '0);
        send_instruction(OP_ADD,  '0);
        send_instruction(OP_PUSH, 32'h0000_0000);
        send_instruction(OP_DIV,  '0);
        send_instruction(OP_PUSH, 32'd5);
        send_instruction(OP_PUSH, 32'd3);
        send_instruction(OP_SUB,  '0);
        send_instruction(OP_PUSH, 32'd7);
        send_instruction(OP_MUL,  '0);
        send_instruction(OP_PUSH, 32'hFFFF_FFF9);
        send_instruction(OP_DIV,  '0);
        send_instruction(OP_TOP,  '0);
        send_instruction(OP_POP,  '0);
        send_instruction(OP_POP,  '0);
        send_instruction(OP_NOP,  '0);

        // Random part in segments: mostly a balanced mix so the depth wanders,
        // with occasional fill runs that hit overflow and drain runs that
        // hit underflow.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            segment = $urandom_range(0, 11);
            if (segment == 0)
            begin
                repeat (70) send_instruction(OP_PUSH, pick_operand());
            end
            else if (segment == 1)
            begin
                repeat (70) send_instruction(op_t'($urandom_range(1, 7)), '0);
            end
            else
            begin
                repeat (20)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        op = OP_PUSH;
                    else if (roll < 52)
                        op = OP_POP;
                    else if (roll < 60)
                        op = OP_TOP;
                    else if (roll < 69)
                        op = OP_ADD;
                    else if (roll < 78)
                        op = OP_SUB;
                    else if (roll < 87)
                        op = OP_MUL;
                    else if (roll < 96)
                        op = OP_DIV;
                    else
                        op = OP_NOP;
                    send_instruction(op, pick_operand());
                end
            end
        end
        cmd_ch.valid = 1'b0;

        // Wait for every outstanding result item, then let the block settle
        // so a stray extra item would still be caught.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
